// File: design/skri_pkg.sv
// Shared types and codes of the sorted key / record index table.
`timescale 1ns / 1ps

package skri_pkg;

	localparam int KEY_W  = 32;
	localparam int RRN_W  = 31;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;

	typedef logic [KIND_W-1:0]        kind_t;
	typedef logic signed [KEY_W-1:0]  key_t;
	typedef logic [RRN_W-1:0]         rrn_t;
	typedef logic [STAT_W-1:0]        status_t;

	// request kinds
	localparam kind_t K_INSERT = 2'd0;
	localparam kind_t K_REMOVE = 2'd1;
	localparam kind_t K_UPDATE = 2'd2;
	localparam kind_t K_FIND   = 2'd3;

	// result status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;

	// one table entry as held in memory
	typedef struct packed {
		key_t key;
		rrn_t rrn;
	} entry_t;

endpackage

// File: design/skri_if.sv
// Request and response channel interfaces of the sorted key / record index table.
`timescale 1ns / 1ps

interface skri_req_if;
	import skri_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	key_t  key;
	rrn_t  rrn;

	modport source (output valid, output kind, output key, output rrn, input ready);
	modport sink   (input valid, input kind, input key, input rrn, output ready);
endinterface

interface skri_rsp_if #(
	parameter int CNT_W = 9
);
	import skri_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	key_t             found_key;
	rrn_t             found_rrn;
	logic [CNT_W-1:0] entry_count;

	modport source (output valid, output status, output found_key, output found_rrn,
		output entry_count, input ready);
	modport sink   (input valid, input status, input found_key, input found_rrn,
		input entry_count, output ready);
endinterface

// File: design/sorted_key_record_index_core.sv
// Sorted key / record-number index table built around one single-port memory.
// Usage
//   req : one word per request (kind, key, rrn). kind selects insert, remove by
//         record number, update (remove then re-insert with a new key) or find
//         by key. The table keeps its entries in ascending signed key order;
//         an insert lands after any entries with an equal key.
//   rsp : exactly one word per request: status, the matched key and record on
//         a successful find (zero otherwise) and the entry count afterwards.
// Operation
//   The table lives in one memory port with a registered read, so each entry
//   visited takes a read state and a check/write-back state. A find stops at
//   its first match, an insert walks down from the tail (none when full), a
//   remove walks every entry and an update does a remove, then an insert.
//   req.ready is high only while the sequencer is idle; the finished result
//   sits in an output register, so a new request is taken while it waits.
// Reset
//   arst_n empties the table at once (count to zero); memory contents are left
//   as they are and only entries below the count are ever read.
// Back-pressure
//   If rsp is stalled and a second result is ready, the sequencer holds in its
//   done state until the output register frees up; nothing is dropped.
`timescale 1ns / 1ps

module sorted_key_record_index_core #(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	skri_req_if.sink   req,
	skri_rsp_if.source rsp
);
	import skri_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RM_RD  = 4'd1;
	localparam logic [3:0] S_RM_CHK = 4'd2;
	localparam logic [3:0] S_RM_END = 4'd3;
	localparam logic [3:0] S_IN_RD  = 4'd4;
	localparam logic [3:0] S_IN_CHK = 4'd5;
	localparam logic [3:0] S_IN_PUT = 4'd6;
	localparam logic [3:0] S_FD_RD  = 4'd7;
	localparam logic [3:0] S_FD_CHK = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]    state_q;
	logic [CW-1:0] total_q;
	logic          found_q;
	logic          rsp_valid_q;

	// request held for the whole sequence
	kind_t         kind_q;
	key_t          key_q;
	rrn_t          rrn_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_dec;

	// result under construction and the output register
	status_t       res_status_q;
	key_t          res_key_q;
	rrn_t          res_rrn_q;
	status_t       rsp_status_q;
	key_t          rsp_key_q;
	rrn_t          rsp_rrn_q;
	logic [CW-1:0] rsp_count_q;

	// memory port
	entry_t        mem [DEPTH];
	entry_t        rd_q;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic          mem_re;

	logic          at_end;
	logic          table_full;
	logic          shift_up;
	logic          rsp_load;

	assign idx_dec    = idx_q - 1'b1;
	assign at_end     = (idx_q == total_q);
	assign table_full = (total_q == CW'(DEPTH));
	// entry moves up while the new key sorts strictly below it
	assign shift_up   = (key_q < rd_q.key);
	assign rsp_load   = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_key   = rsp_key_q;
	assign rsp.found_rrn   = rsp_rrn_q;
	assign rsp.entry_count = rsp_count_q;

	// memory port control: one read or one write per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = idx_q[AW-1:0];
		mem_wdata = rd_q;
		case (state_q)
			S_RM_RD, S_FD_RD: begin
				mem_re = !at_end;
			end
			S_RM_CHK: begin
				// close the gap: entry i drops to i-1 once the victim is behind us
				mem_we   = found_q;
				mem_addr = idx_dec[AW-1:0];
			end
			S_IN_RD: begin
				mem_re   = (idx_q != '0);
				mem_addr = idx_dec[AW-1:0];
			end
			S_IN_CHK: begin
				mem_we = shift_up;
			end
			S_IN_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = '{key: key_q, rrn: rrn_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						found_q <= 1'b0;
						case (req.kind)
							K_INSERT: state_q <= table_full ? S_DONE : S_IN_RD;
							K_REMOVE, K_UPDATE: state_q <= S_RM_RD;
							default: state_q <= S_FD_RD;
						endcase
					end
				end
				S_RM_RD: begin
					state_q <= at_end ? S_RM_END : S_RM_CHK;
				end
				S_RM_CHK: begin
					if (!found_q && rd_q.rrn == rrn_q) begin
						found_q <= 1'b1;
					end
					state_q <= S_RM_RD;
				end
				S_RM_END: begin
					if (found_q) begin
						total_q <= total_q - 1'b1;
						state_q <= (kind_q == K_UPDATE) ? S_IN_RD : S_DONE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_IN_RD: begin
					state_q <= (idx_q == '0) ? S_IN_PUT : S_IN_CHK;
				end
				S_IN_CHK: begin
					state_q <= shift_up ? S_IN_RD : S_IN_PUT;
				end
				S_IN_PUT: begin
					total_q <= total_q + 1'b1;
					state_q <= S_DONE;
				end
				S_FD_RD: begin
					state_q <= at_end ? S_DONE : S_FD_CHK;
				end
				S_FD_CHK: begin
					state_q <= (rd_q.key == key_q) ? S_DONE : S_FD_RD;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: request, index walk and result
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_key_q    <= res_key_q;
			rsp_rrn_q    <= res_rrn_q;
			rsp_count_q  <= total_q;
		end
		case (state_q)
			S_IDLE: begin
				kind_q       <= req.kind;
				key_q        <= req.key;
				rrn_q        <= req.rrn;
				res_key_q    <= '0;
				res_rrn_q    <= '0;
				res_status_q <= ST_OK;
				if (req.kind == K_INSERT) begin
					idx_q <= total_q;
					if (table_full) begin
						res_status_q <= ST_FULL;
					end
				end else begin
					idx_q <= '0;
				end
			end
			S_RM_CHK: begin
				idx_q <= idx_q + 1'b1;
			end
			S_RM_END: begin
				// re-insert of an update starts from the top of the shrunk table
				idx_q <= total_q - 1'b1;
				if (!found_q) begin
					res_status_q <= ST_NOT_FOUND;
				end
			end
			S_IN_CHK: begin
				if (shift_up) begin
					idx_q <= idx_dec;
				end
			end
			S_FD_RD: begin
				if (at_end) begin
					res_status_q <= ST_NOT_FOUND;
				end
			end
			S_FD_CHK: begin
				if (rd_q.key == key_q) begin
					res_key_q <= rd_q.key;
					res_rrn_q <= rd_q.rrn;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(DEPTH))
		else $error("entry count beyond table depth");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.entry_count == CW'(DEPTH))
		else $error("full reported with free slots");

	a_miss_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.found_key == '0 && rsp.found_rrn == '0)
		else $error("match fields set on a failed request");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != S_IDLE)
		else $error("accepted request not started");
`endif

endmodule

// File: verif/sorted_key_record_index_core_test.sv
// Self-checking testbench of the sorted key / record index table core.
`timescale 1ns / 1ps

module sorted_key_record_index_core_test;
	import skri_pkg::*;

	localparam int     TABLE_DEPTH  = 256;
	localparam int     COUNT_W      = 9;
	localparam longint RUN_LIMIT_NS = 64'd80_000_000;
	// an update on a full table can visit every entry twice over
	localparam int     SETTLE_CYCLES = 4 * TABLE_DEPTH + 64;
	localparam int     DRAIN_LIMIT   = 200_000;

	localparam key_t KEY_TOP    = 32'sh7fff_ffff;
	localparam key_t KEY_BOTTOM = 32'sh8000_0000;
	localparam rrn_t RRN_TOP    = 31'h7fff_ffff;

	// one expected result word
	typedef struct packed {
		status_t            status;
		key_t               found_key;
		rrn_t               found_rrn;
		logic [COUNT_W-1:0] entry_count;
	} index_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	skri_req_if                     req ();
	skri_rsp_if #(.CNT_W(COUNT_W)) rsp ();

	sorted_key_record_index_core #(
		.DEPTH(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always #5 clk = ~clk;

	// Shadow of the table, kept in position order exactly as the block holds it.
	key_t          held_keys[$];
	rrn_t          held_rrns[$];
	index_result_t expected_results[$];

	int error_count   = 0;
	int words_checked = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic rsp_blocked = 1'b0;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Drop the first entry, in position order, carrying this record number.
	function automatic status_t table_remove(rrn_t rrn);
		int pos;
		for (pos = 0; pos < held_rrns.size(); pos++) begin
			if (held_rrns[pos] == rrn) begin
				held_keys.delete(pos);
				held_rrns.delete(pos);
				return ST_OK;
			end
		end
		return ST_NOT_FOUND;
	endfunction

	// Place the pair after every entry whose key is equal or lower.
	function automatic status_t table_insert(key_t key, rrn_t rrn);
		int pos;
		if (held_keys.size() >= TABLE_DEPTH)
			return ST_FULL;
		pos = 0;
		while (pos < held_keys.size() && !(key < held_keys[pos]))
			pos++;
		held_keys.insert(pos, key);
		held_rrns.insert(pos, rrn);
		return ST_OK;
	endfunction

	function automatic index_result_t predict_index_result(kind_t op, key_t key, rrn_t rrn);
		index_result_t res;
		int            pos;
		res = '0;
		case (op)
			K_INSERT: res.status = table_insert(key, rrn);
			K_REMOVE: res.status = table_remove(rrn);
			K_UPDATE: begin
				res.status = table_remove(rrn);
				if (res.status == ST_OK)
					res.status = table_insert(key, rrn);
			end
			default: begin
				res.status = ST_NOT_FOUND;
				for (pos = 0; pos < held_keys.size(); pos++) begin
					if (held_keys[pos] == key) begin
						res.status    = ST_OK;
						res.found_key = held_keys[pos];
						res.found_rrn = held_rrns[pos];
						break;
					end
				end
			end
		endcase
		res.entry_count = COUNT_W'(held_keys.size());
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offer one request word; return once it has been taken, leaving valid high.
	task automatic send_request(kind_t op, key_t key, rrn_t rrn);
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind  <= op;
		req.key   <= key;
		req.rrn   <= rrn;
		do @(posedge clk); while (req.ready !== 1'b1);
		expected_results.push_back(predict_index_result(op, key, rrn));
	endtask

	// Pause the sender until every outstanding result has been returned.
	task automatic wait_drained();
		req.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// Mostly keys near zero so that finds hit and equal keys pile up.
	function automatic key_t pick_key();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40 && held_keys.size() != 0)
			return held_keys[$urandom_range(held_keys.size() - 1)];
		if (roll < 75)
			return key_t'($signed($urandom_range(16)) - 8);
		if (roll < 80)
			return ($urandom_range(1)) ? KEY_TOP : KEY_BOTTOM;
		return key_t'($urandom());
	endfunction

	// Mostly record numbers already held or from a small pool.
	function automatic rrn_t pick_rrn();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50 && held_rrns.size() != 0)
			return held_rrns[$urandom_range(held_rrns.size() - 1)];
		if (roll < 80)
			return rrn_t'($urandom_range(40));
		if (roll < 83)
			return RRN_TOP;
		return rrn_t'($urandom());
	endfunction

	// ------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		error_count++;
		$display("[%0t] word %0d %s: got %0h, expected %0h",
			$realtime, words_checked, what, got, want);
	endtask

	task automatic check_result_word();
		index_result_t want;
		words_checked++;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing outstanding", 64'(rsp.entry_count), 64'd0);
			return;
		end
		want = expected_results.pop_front();
		if (rsp.status !== want.status)
			report_mismatch("status", 64'(rsp.status), 64'(want.status));
		if (rsp.found_key !== want.found_key)
			report_mismatch("found_key", 64'(rsp.found_key), 64'(want.found_key));
		if (rsp.found_rrn !== want.found_rrn)
			report_mismatch("found_rrn", 64'(rsp.found_rrn), 64'(want.found_rrn));
		if (rsp.entry_count !== want.entry_count)
			report_mismatch("entry_count", 64'(rsp.entry_count), 64'(want.entry_count));
	endtask

	// Take result words on the edge, then decide ready for the next edge.
	always @(posedge clk) begin
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
			check_result_word();
		if (!arst_n || rsp_blocked) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Find, remove and update against an empty table: nothing to find, nothing to remove.
	task automatic test_empty_table();
		send_request(K_FIND,   KEY_BOTTOM, '0);
		send_request(K_FIND,   KEY_TOP,    RRN_TOP);
		send_request(K_REMOVE, '0,         RRN_TOP);
		send_request(K_UPDATE, 32'sd17,    rrn_t'(3));
		wait_drained();
	endtask

	// Key extremes, equal keys, repeated record numbers and updates that move entries.
	task automatic test_ordering();
		send_request(K_INSERT, KEY_TOP,    '0);
		send_request(K_INSERT, KEY_BOTTOM, RRN_TOP);
		send_request(K_INSERT, 32'sd0,     rrn_t'(5));
		send_request(K_INSERT, -32'sd1,    rrn_t'(6));
		// equal keys: the later insert lands behind, find returns the earlier one
		send_request(K_INSERT, 32'sd5,     rrn_t'(1));
		send_request(K_INSERT, 32'sd5,     rrn_t'(2));
		send_request(K_FIND,   32'sd5,     '0);
		send_request(K_FIND,   KEY_BOTTOM, '0);
		send_request(K_FIND,   KEY_TOP,    '0);
		send_request(K_FIND,   32'sd4,     '0);
		// same record number twice: remove takes the lower position only
		send_request(K_INSERT, -32'sd3,    rrn_t'(7));
		send_request(K_INSERT, 32'sd9,     rrn_t'(7));
		send_request(K_REMOVE, '0,         rrn_t'(7));
		send_request(K_FIND,   -32'sd3,    '0);
		send_request(K_FIND,   32'sd9,     '0);
		send_request(K_REMOVE, '0,         rrn_t'(1));
		send_request(K_FIND,   32'sd5,     '0);
		// move a record onto the lowest key, behind the one already there
		send_request(K_UPDATE, KEY_BOTTOM, rrn_t'(2));
		send_request(K_FIND,   KEY_BOTTOM, '0);
		send_request(K_UPDATE, 32'sd3,     rrn_t'(99));
		send_request(K_REMOVE, '0,         RRN_TOP);
		wait_drained();
	endtask

	// Fill every slot, then hit the full cases: insert refused, update still allowed.
	task automatic test_full_table();
		int   n;
		rrn_t victim;
		while (held_rrns.size() != 0)
			send_request(K_REMOVE, '0, held_rrns[0]);
		// ascending keys keep each insert at the tail, which is cheap
		for (n = 0; n < TABLE_DEPTH; n++)
			send_request(K_INSERT, key_t'(n * 8 - 1024), rrn_t'($urandom()));
		send_request(K_INSERT, KEY_TOP,    RRN_TOP);
		send_request(K_INSERT, KEY_BOTTOM, '0);
		send_request(K_FIND,   key_t'((TABLE_DEPTH - 1) * 8 - 1024), '0);
		send_request(K_UPDATE, KEY_TOP, held_rrns[0]);
		send_request(K_FIND,   KEY_TOP, '0);
		send_request(K_INSERT, 32'sd0, rrn_t'(12));
		victim = held_rrns[$urandom_range(TABLE_DEPTH - 1)];
		send_request(K_REMOVE, '0, victim);
		send_request(K_INSERT, 32'sd0, rrn_t'(12));
		wait_drained();
	endtask

	// Empty a full table down to a handful, removing from random positions.
	task automatic test_drain_table();
		while (held_rrns.size() > 12) begin
			if ($urandom_range(19) == 0)
				send_request(K_REMOVE, '0, rrn_t'($urandom()));
			else
				send_request(K_REMOVE, '0, held_rrns[$urandom_range(held_rrns.size() - 1)]);
		end
		wait_drained();
	endtask

	// Hold the result channel off for a long stretch while requests keep coming,
	// so that the output register and the sequencer fill and req.ready drops.
	task automatic test_result_backpressure();
		int n;
		fork
			begin
				rsp_blocked <= 1'b1;
				repeat (400) @(posedge clk);
				rsp_blocked <= 1'b0;
			end
			for (n = 0; n < 16; n++) begin
				if (n % 3 == 0)
					send_request(K_INSERT, pick_key(), pick_rrn());
				else
					send_request(K_FIND, pick_key(), '0);
			end
		join
		wait_drained();
	endtask

	// Random mix of all kinds; the table size wanders but stays small.
	task automatic test_random_mix(int count);
		int    n;
		int    roll;
		kind_t op;
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 35 && held_keys.size() > 40)
				roll = 40;
			if (roll < 35)
				op = K_INSERT;
			else if (roll < 55)
				op = K_REMOVE;
			else if (roll < 75)
				op = K_UPDATE;
			else
				op = K_FIND;
			send_request(op, pick_key(), pick_rrn());
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		int spin;
		req.valid <= 1'b0;
		req.kind  <= K_INSERT;
		req.key   <= '0;
		req.rrn   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 17;
		recv_idle_pct = 51;
		test_empty_table();
		test_ordering();
		test_full_table();

		send_idle_pct = 51;
		recv_idle_pct = 17;
		test_drain_table();
		test_result_backpressure();

		send_idle_pct = 17;
		recv_idle_pct = 51;
		test_random_mix(110);
		send_idle_pct = 51;
		recv_idle_pct = 17;
		test_random_mix(110);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(110);

		// hold on for anything still in flight, then watch for stray words
		for (spin = 0; spin < DRAIN_LIMIT && expected_results.size() != 0; spin++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (expected_results.size() != 0) begin
			report_mismatch("result never returned", 64'd0, 64'(expected_results[0].status));
			void'(expected_results.pop_front());
		end

		if (error_count == 0) begin
			$display("sorted_key_record_index_core_test OK");
		end else begin
			$display("sorted_key_record_index_core_test NOT OK");
		end
		$finish;
	end

	// Abandon a hung run.
	initial begin
		#(RUN_LIMIT_NS);
		$display("sorted_key_record_index_core_test NOT OK");
		$finish;
	end

endmodule
